[hw/rtl/oat_pkg.sv]
// ---------------------------------------------------------------------------
// oat_pkg: types, codes and control store for the ordered array table
// Holds the command and status codes, the control word layout of the
// sequencer, the step addresses, and the read-only program itself.
// ---------------------------------------------------------------------------
package oat_pkg;

  // Command codes carried by the input word
  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_SEARCH = 3'd3,
    CMD_POP    = 3'd4,
    CMD_MAX    = 3'd5,
    CMD_MIN    = 3'd6
  } cmd_e;

  // Status codes carried by the result word
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADIDX   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // Branch conditions tested by a control word
  typedef enum logic [3:0] {
    C_NEVER         = 4'd0,
    C_ALWAYS        = 4'd1,
    C_IN_VALID      = 4'd2,
    C_DISPATCH      = 4'd3,
    C_FULL          = 4'd4,
    C_EMPTY         = 4'd5,
    C_INS_BAD       = 4'd6,
    C_DEL_BAD       = 4'd7,
    C_PTR_GT_POS    = 4'd8,
    C_PTR_P1_LT_CNT = 4'd9,
    C_PTR_LT_CNT    = 4'd10,
    C_MATCH         = 4'd11,
    C_OUT_BUSY      = 4'd12
  } cond_e;

  // Walk pointer operations
  typedef enum logic [2:0] {
    P_HOLD = 3'd0,
    P_CNT  = 3'd1,
    P_POS  = 3'd2,
    P_ZERO = 3'd3,
    P_INC  = 3'd4,
    P_DEC  = 3'd5
  } ptr_op_e;

  // Word count operations
  typedef enum logic [1:0] {
    N_HOLD = 2'd0,
    N_INC  = 2'd1,
    N_DEC  = 2'd2
  } cnt_op_e;

  // Accumulator operations
  typedef enum logic [1:0] {
    A_HOLD  = 2'd0,
    A_RDATA = 2'd1,
    A_BEST  = 2'd2
  } acc_op_e;

  // Store read address select
  typedef enum logic [1:0] {
    R_PTR    = 2'd0,
    R_PTR_M1 = 2'd1,
    R_PTR_P1 = 2'd2
  } rd_sel_e;

  typedef logic [4:0] upc_t;

  // One control word of the program
  typedef struct packed {
    logic    accept;   // take an input word in this step
    logic    clr;      // clear result status, value and index
    logic    emit;     // hand the result to the output register
    logic    wr_en;    // write the store at the walk pointer
    logic    wr_val;   // write data: 1 input value, 0 read data
    logic    ridx_ld;  // on a taken branch, capture the pointer as index
    logic    stat_en;  // on a taken branch, set the status
    status_e stat;
    rd_sel_e rd_sel;
    ptr_op_e ptr_op;
    cnt_op_e cnt_op;
    acc_op_e acc_op;
    cond_e   cond;
    logic    inv;      // invert the condition
    upc_t    jmp;      // target when the branch is taken
    upc_t    nxt;      // target otherwise
  } ucw_t;

  // Step addresses
  localparam upc_t U_IDLE = 5'd0;
  localparam upc_t U_DISP = 5'd1;
  localparam upc_t U_AP0  = 5'd2;
  localparam upc_t U_AP1  = 5'd3;
  localparam upc_t U_IN0  = 5'd4;
  localparam upc_t U_IN1  = 5'd5;
  localparam upc_t U_IN2  = 5'd6;
  localparam upc_t U_IN3  = 5'd7;
  localparam upc_t U_IN4  = 5'd8;
  localparam upc_t U_DL0  = 5'd9;
  localparam upc_t U_DL1  = 5'd10;
  localparam upc_t U_DL2  = 5'd11;
  localparam upc_t U_DL3  = 5'd12;
  localparam upc_t U_DL4  = 5'd13;
  localparam upc_t U_DL5  = 5'd14;
  localparam upc_t U_SR0  = 5'd15;
  localparam upc_t U_SR1  = 5'd16;
  localparam upc_t U_SR2  = 5'd17;
  localparam upc_t U_SR3  = 5'd18;
  localparam upc_t U_MX0  = 5'd19;
  localparam upc_t U_MX1  = 5'd20;
  localparam upc_t U_MX2  = 5'd21;
  localparam upc_t U_MX3  = 5'd22;
  localparam upc_t U_MX4  = 5'd23;
  localparam upc_t U_PP0  = 5'd24;
  localparam upc_t U_PP1  = 5'd25;
  localparam upc_t U_DONE = 5'd26;

  // Entry step of each command; unused codes go straight to the result
  function automatic upc_t cmd_entry(cmd_e cmd);
    upc_t a;
    case (cmd)
      CMD_APPEND: a = U_AP0;
      CMD_INSERT: a = U_IN0;
      CMD_DELETE: a = U_DL0;
      CMD_SEARCH: a = U_SR0;
      CMD_POP:    a = U_PP0;
      CMD_MAX:    a = U_MX0;
      CMD_MIN:    a = U_MX0;
      default:    a = U_DONE;
    endcase
    return a;
  endfunction

  // Control store
  function automatic ucw_t ucode(upc_t a);
    ucw_t w;
    w = '0;
    case (a)
      // Wait for a word, reset the result fields
      U_IDLE: begin
        w.accept = 1'b1; w.clr = 1'b1;
        w.cond = C_IN_VALID; w.inv = 1'b1; w.jmp = U_IDLE; w.nxt = U_DISP;
      end
      U_DISP: begin
        w.cond = C_DISPATCH; w.jmp = U_DONE; w.nxt = U_DONE;
      end
      // Append
      U_AP0: begin
        w.cond = C_FULL; w.stat_en = 1'b1; w.stat = ST_FULL;
        w.jmp = U_DONE; w.nxt = U_AP1; w.ptr_op = P_CNT;
      end
      U_AP1: begin
        w.wr_en = 1'b1; w.wr_val = 1'b1; w.cnt_op = N_INC; w.nxt = U_DONE;
      end
      // Insert: shift upward from the end down to the position
      U_IN0: begin
        w.cond = C_FULL; w.stat_en = 1'b1; w.stat = ST_FULL;
        w.jmp = U_DONE; w.nxt = U_IN1; w.ptr_op = P_CNT;
      end
      U_IN1: begin
        w.cond = C_INS_BAD; w.stat_en = 1'b1; w.stat = ST_BADIDX;
        w.jmp = U_DONE; w.nxt = U_IN2;
      end
      U_IN2: begin
        w.rd_sel = R_PTR_M1; w.cond = C_PTR_GT_POS; w.inv = 1'b1;
        w.jmp = U_IN4; w.nxt = U_IN3;
      end
      U_IN3: begin
        w.wr_en = 1'b1; w.ptr_op = P_DEC; w.nxt = U_IN2;
      end
      U_IN4: begin
        w.wr_en = 1'b1; w.wr_val = 1'b1; w.cnt_op = N_INC; w.nxt = U_DONE;
      end
      // Delete: capture the word, shift downward
      U_DL0: begin
        w.cond = C_EMPTY; w.stat_en = 1'b1; w.stat = ST_EMPTY;
        w.jmp = U_DONE; w.nxt = U_DL1; w.ptr_op = P_POS;
      end
      U_DL1: begin
        w.cond = C_DEL_BAD; w.stat_en = 1'b1; w.stat = ST_BADIDX;
        w.jmp = U_DONE; w.nxt = U_DL2; w.rd_sel = R_PTR;
      end
      U_DL2: begin
        w.acc_op = A_RDATA; w.nxt = U_DL3;
      end
      U_DL3: begin
        w.rd_sel = R_PTR_P1; w.cond = C_PTR_P1_LT_CNT; w.inv = 1'b1;
        w.jmp = U_DL5; w.nxt = U_DL4;
      end
      U_DL4: begin
        w.wr_en = 1'b1; w.ptr_op = P_INC; w.nxt = U_DL3;
      end
      U_DL5: begin
        w.cnt_op = N_DEC; w.nxt = U_DONE;
      end
      // Search: first equal word
      U_SR0: begin
        w.cond = C_EMPTY; w.stat_en = 1'b1; w.stat = ST_EMPTY;
        w.jmp = U_DONE; w.nxt = U_SR1; w.ptr_op = P_ZERO;
      end
      U_SR1: begin
        w.cond = C_ALWAYS; w.stat_en = 1'b1; w.stat = ST_NOTFOUND;
        w.jmp = U_SR2; w.nxt = U_SR2;
      end
      U_SR2: begin
        w.rd_sel = R_PTR; w.cond = C_PTR_LT_CNT; w.inv = 1'b1;
        w.jmp = U_DONE; w.nxt = U_SR3;
      end
      U_SR3: begin
        w.cond = C_MATCH; w.stat_en = 1'b1; w.stat = ST_OK; w.ridx_ld = 1'b1;
        w.jmp = U_DONE; w.nxt = U_SR2; w.ptr_op = P_INC;
      end
      // Maximum or minimum
      U_MX0: begin
        w.cond = C_EMPTY; w.stat_en = 1'b1; w.stat = ST_EMPTY;
        w.jmp = U_DONE; w.nxt = U_MX1; w.ptr_op = P_ZERO;
      end
      U_MX1: begin
        w.rd_sel = R_PTR; w.ptr_op = P_INC; w.nxt = U_MX2;
      end
      U_MX2: begin
        w.acc_op = A_RDATA; w.nxt = U_MX3;
      end
      U_MX3: begin
        w.rd_sel = R_PTR; w.cond = C_PTR_LT_CNT; w.inv = 1'b1;
        w.jmp = U_DONE; w.nxt = U_MX4;
      end
      U_MX4: begin
        w.acc_op = A_BEST; w.ptr_op = P_INC; w.nxt = U_MX3;
      end
      // Pop
      U_PP0: begin
        w.cond = C_EMPTY; w.stat_en = 1'b1; w.stat = ST_EMPTY;
        w.jmp = U_DONE; w.nxt = U_PP1;
      end
      U_PP1: begin
        w.cnt_op = N_DEC; w.nxt = U_DONE;
      end
      // Hand over the result once the output register is free
      U_DONE: begin
        w.emit = 1'b1; w.cond = C_OUT_BUSY; w.jmp = U_DONE; w.nxt = U_IDLE;
      end
      default: begin
        w.nxt = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/ordered_array_table.sv]
// ---------------------------------------------------------------------------
// ordered_array_table: bounded ordered array of signed words
// Executes one command per input word (append, insert, delete, search,
// pop, maximum, minimum) and returns one result word per command.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries command_i, position_i
//   and item_value_i. Output channel (out_valid_o / out_ready_i) carries
//   status_o, result_value_o, result_index_o, entry_count_o and the flags.
//   A microcoded sequencer runs one command at a time over a word store
//   (one write and one registered read per cycle); in_ready_o is high
//   only while the sequencer waits for a new word.
// Insert and delete walk the words between the position and the end,
// search walks up to the first hit, maximum and minimum walk every word.
// Each walked word costs two steps: read, then write or compare on the
// registered read data.
// The result sits in an output register, so the next word is accepted as
// soon as the result is loaded; a stalled receiver holds the sequencer in
// its final step until the register frees up.
// Reset empties the table (count zero); the store itself is not cleared.
// ---------------------------------------------------------------------------
module ordered_array_table #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         command_i,
  input  logic [3:0]         position_i,
  input  logic signed [31:0] item_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] result_value_o,
  output logic [3:0]         result_index_o,
  output logic [4:0]         entry_count_o,
  output logic               empty_flag_o,
  output logic               full_flag_o
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = $clog2(CAPACITY);
  localparam int CmpW = (CntW > 4) ? CntW : 4;

  // Sequencer and datapath registers
  oat_pkg::upc_t    upc_q, upc_d;
  oat_pkg::cmd_e    cmd_q;
  logic [3:0]       pos_q;
  logic [31:0]      val_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  ptr_q, ptr_d;
  logic [31:0]      acc_q, acc_d;
  logic [3:0]       ridx_q, ridx_d;
  oat_pkg::status_e stat_q, stat_d;
  logic [31:0]      rdata_q;

  // Output register
  logic             out_valid_q;
  oat_pkg::status_e out_stat_q;
  logic [31:0]      out_val_q;
  logic [3:0]       out_idx_q;
  logic [4:0]       out_cnt_q;
  logic             out_empty_q;
  logic             out_full_q;

  oat_pkg::ucw_t    uw;
  logic             cond_raw;
  logic             taken;
  logic             emit_fire;
  logic             in_fire;
  logic             better;
  logic [CmpW-1:0]  pos_ext, cnt_ext, ptr_ext;
  logic [CntW:0]    ptr_p1_w;
  logic [CntW-1:0]  ptr_m1, ptr_p1;
  logic [IdxW-1:0]  rd_addr, wr_addr;
  logic [31:0]      wr_data;

  logic [31:0]      mem_q [CAPACITY];

  // Fetch the control word of the current step
  assign uw = oat_pkg::ucode(upc_q);

  assign in_ready_o = uw.accept;
  assign in_fire    = in_valid_i & uw.accept;

  assign pos_ext  = CmpW'(pos_q);
  assign cnt_ext  = CmpW'(cnt_q);
  assign ptr_ext  = CmpW'(ptr_q);
  assign ptr_p1_w = {1'b0, ptr_q} + (CntW + 1)'(1);
  assign ptr_m1   = ptr_q - CntW'(1);
  assign ptr_p1   = ptr_q + CntW'(1);

  // Signed compare of read data against the running extreme
  assign better = (cmd_q == oat_pkg::CMD_MAX) ? ($signed(rdata_q) > $signed(acc_q))
                                              : ($signed(rdata_q) < $signed(acc_q));

  // Evaluate the branch condition
  always_comb begin
    case (uw.cond)
      oat_pkg::C_NEVER:         cond_raw = 1'b0;
      oat_pkg::C_ALWAYS:        cond_raw = 1'b1;
      oat_pkg::C_IN_VALID:      cond_raw = in_valid_i;
      oat_pkg::C_DISPATCH:      cond_raw = 1'b1;
      oat_pkg::C_FULL:          cond_raw = (cnt_q == CntW'(CAPACITY));
      oat_pkg::C_EMPTY:         cond_raw = (cnt_q == '0);
      oat_pkg::C_INS_BAD:       cond_raw = (pos_ext > cnt_ext);
      oat_pkg::C_DEL_BAD:       cond_raw = (pos_ext >= cnt_ext);
      oat_pkg::C_PTR_GT_POS:    cond_raw = (ptr_ext > pos_ext);
      oat_pkg::C_PTR_P1_LT_CNT: cond_raw = (ptr_p1_w < {1'b0, cnt_q});
      oat_pkg::C_PTR_LT_CNT:    cond_raw = (ptr_q < cnt_q);
      oat_pkg::C_MATCH:         cond_raw = (rdata_q == val_q);
      oat_pkg::C_OUT_BUSY:      cond_raw = out_valid_q & ~out_ready_i;
      default:                  cond_raw = 1'b0;
    endcase
  end

  assign taken     = cond_raw ^ uw.inv;
  assign emit_fire = uw.emit & ~taken;

  // Select the next step
  always_comb begin
    if (!taken) begin
      upc_d = uw.nxt;
    end else if (uw.cond == oat_pkg::C_DISPATCH) begin
      upc_d = oat_pkg::cmd_entry(cmd_q);
    end else begin
      upc_d = uw.jmp;
    end
  end

  // Datapath next values
  always_comb begin
    case (uw.ptr_op)
      oat_pkg::P_HOLD: ptr_d = ptr_q;
      oat_pkg::P_CNT:  ptr_d = cnt_q;
      oat_pkg::P_POS:  ptr_d = CntW'(pos_ext);
      oat_pkg::P_ZERO: ptr_d = '0;
      oat_pkg::P_INC:  ptr_d = ptr_p1;
      oat_pkg::P_DEC:  ptr_d = ptr_m1;
      default:         ptr_d = ptr_q;
    endcase

    case (uw.cnt_op)
      oat_pkg::N_HOLD: cnt_d = cnt_q;
      oat_pkg::N_INC:  cnt_d = cnt_q + CntW'(1);
      oat_pkg::N_DEC:  cnt_d = cnt_q - CntW'(1);
      default:         cnt_d = cnt_q;
    endcase

    case (uw.acc_op)
      oat_pkg::A_HOLD:  acc_d = acc_q;
      oat_pkg::A_RDATA: acc_d = rdata_q;
      oat_pkg::A_BEST:  acc_d = better ? rdata_q : acc_q;
      default:          acc_d = acc_q;
    endcase
    if (uw.clr) begin
      acc_d = '0;
    end

    stat_d = stat_q;
    ridx_d = ridx_q;
    if (uw.clr) begin
      stat_d = oat_pkg::ST_OK;
      ridx_d = '0;
    end
    if (taken && uw.stat_en) begin
      stat_d = uw.stat;
    end
    if (taken && uw.ridx_ld) begin
      ridx_d = 4'(ptr_q);
    end
  end

  // Store addressing
  always_comb begin
    case (uw.rd_sel)
      oat_pkg::R_PTR:    rd_addr = IdxW'(ptr_q);
      oat_pkg::R_PTR_M1: rd_addr = IdxW'(ptr_m1);
      oat_pkg::R_PTR_P1: rd_addr = IdxW'(ptr_p1);
      default:           rd_addr = IdxW'(ptr_q);
    endcase
  end

  assign wr_addr = IdxW'(ptr_q);
  assign wr_data = uw.wr_val ? val_q : rdata_q;

  // Word store: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (uw.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Latch the accepted word and datapath payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= oat_pkg::cmd_e'(command_i);
      pos_q <= position_i;
      val_q <= item_value_i;
    end
    ptr_q  <= ptr_d;
    acc_q  <= acc_d;
    ridx_q <= ridx_d;
    stat_q <= stat_d;
  end

  // Step counter and word count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= oat_pkg::U_IDLE;
      cnt_q <= '0;
    end else begin
      upc_q <= upc_d;
      cnt_q <= cnt_d;
    end
  end

  // Output register: load on emit, drop on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_stat_q  <= stat_q;
      out_val_q   <= acc_q;
      out_idx_q   <= ridx_q;
      out_cnt_q   <= 5'(cnt_q);
      out_empty_q <= (cnt_q == '0);
      out_full_q  <= (cnt_q == CntW'(CAPACITY));
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_stat_q;
  assign result_value_o = out_val_q;
  assign result_index_o = out_idx_q;
  assign entry_count_o  = out_cnt_q;
  assign empty_flag_o   = out_empty_q;
  assign full_flag_o    = out_full_q;

`ifndef SYNTHESIS
  // Count never exceeds capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("word count above capacity");

  // Every store write lands inside the table
  a_wr_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uw.wr_en |-> (ptr_q < CntW'(CAPACITY)))
    else $error("store write beyond capacity");

  // An accepted word moves the sequencer to dispatch
  a_accept_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (upc_q == oat_pkg::U_DISP))
    else $error("accepted word not dispatched");

  // A result is loaded only when the output register is free or draining
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a pending output");
`endif

endmodule

[tb/sv/tb_ordered_array_table.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ordered_array_table: self-checking bench for the ordered array table
// Drives commands over the valid/ready input channel and predicts every
// result word from a behavioral copy of the table. Each result is compared
// field by field against the oldest prediction. Covers empty and full
// refusals, bad indexes, search hits and misses, signed extremes, random
// command streams with idle bursts on both sides, and a long receiver stall.
// ---------------------------------------------------------------------------
module tb_ordered_array_table;

  localparam int         TABLE_DEPTH    = 16;
  localparam logic [2:0] CMD_UNUSED     = 3'd7;
  localparam int         LONG_HOLD      = 200;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         DRAIN_CYCLES   = 2 * TABLE_DEPTH + 16;

  typedef struct packed {
    oat_pkg::status_e status;
    logic [31:0]      value;
    logic [3:0]       index;
    logic [4:0]       count;
    logic             empty;
    logic             full;
  } table_result_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [2:0]         command_i      = '0;
  logic [3:0]         position_i     = '0;
  logic signed [31:0] item_value_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic [2:0]         status_o;
  logic signed [31:0] result_value_o;
  logic [3:0]         result_index_o;
  logic [4:0]         entry_count_o;
  logic               empty_flag_o;
  logic               full_flag_o;

  // Behavioral copy of the table
  logic signed [31:0] model_words [TABLE_DEPTH];
  int                 model_count = 0;

  table_result_t pending_results[$];
  int            error_count    = 0;
  int            words_sent     = 0;
  int            results_seen   = 0;
  int            status_tally[5] = '{default: 0};
  int            quiet_cycles   = 0;
  bit            sender_gaps    = 1'b1;
  bit            sink_stalls    = 1'b1;
  bit            long_hold_req  = 1'b0;

  ordered_array_table #(
    .CAPACITY(TABLE_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .position_i     (position_i),
    .item_value_i   (item_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .result_value_o (result_value_o),
    .result_index_o (result_index_o),
    .entry_count_o  (entry_count_o),
    .empty_flag_o   (empty_flag_o),
    .full_flag_o    (full_flag_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the table copy by one command and return the result it yields
  function automatic table_result_t apply_command(logic [2:0] cmd, logic [3:0] pos,
                                                  logic [31:0] val);
    table_result_t      r;
    int                 i;
    logic               is_full;
    logic               is_empty;
    logic signed [31:0] best;
    r        = '0;
    r.status = oat_pkg::ST_OK;
    is_full  = model_count >= TABLE_DEPTH;
    is_empty = model_count == 0;
    case (cmd)
      oat_pkg::CMD_APPEND: begin
        if (is_full) begin
          r.status = oat_pkg::ST_FULL;
        end else begin
          model_words[model_count] = val;
          model_count++;
        end
      end
      oat_pkg::CMD_INSERT: begin
        if (is_full) begin
          r.status = oat_pkg::ST_FULL;
        end else if (pos > model_count) begin
          r.status = oat_pkg::ST_BADIDX;
        end else begin
          for (i = model_count; i > pos; i--) model_words[i] = model_words[i - 1];
          model_words[pos] = val;
          model_count++;
        end
      end
      oat_pkg::CMD_DELETE: begin
        if (is_empty) begin
          r.status = oat_pkg::ST_EMPTY;
        end else if (pos >= model_count) begin
          r.status = oat_pkg::ST_BADIDX;
        end else begin
          r.value = model_words[pos];
          for (i = pos; i + 1 < model_count; i++) model_words[i] = model_words[i + 1];
          model_count--;
        end
      end
      oat_pkg::CMD_SEARCH: begin
        if (is_empty) begin
          r.status = oat_pkg::ST_EMPTY;
        end else begin
          r.status = oat_pkg::ST_NOTFOUND;
          for (i = 0; i < model_count; i++) begin
            if (model_words[i] == val) begin
              r.status = oat_pkg::ST_OK;
              r.index  = 4'(i);
              break;
            end
          end
        end
      end
      oat_pkg::CMD_POP: begin
        if (is_empty) r.status = oat_pkg::ST_EMPTY;
        else model_count--;
      end
      oat_pkg::CMD_MAX, oat_pkg::CMD_MIN: begin
        if (is_empty) begin
          r.status = oat_pkg::ST_EMPTY;
        end else begin
          best = model_words[0];
          for (i = 1; i < model_count; i++) begin
            if ((cmd == oat_pkg::CMD_MAX) ? (model_words[i] > best)
                                          : (model_words[i] < best))
              best = model_words[i];
          end
          r.value = best;
        end
      end
      default: begin
        // unused code: leave the table alone
      end
    endcase
    r.count = 5'(model_count);
    r.empty = model_count == 0;
    r.full  = model_count == TABLE_DEPTH;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("[%0t] mismatch in %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Offer one word, hold it until taken, then record its prediction
  task automatic send_word(logic [2:0] cmd, logic [3:0] pos, logic [31:0] val);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    position_i   <= pos;
    item_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(apply_command(cmd, pos, val));
    words_sent++;
  endtask

  // Random command stream, steered so the table fills and drains in turn
  task automatic run_mix(int n);
    logic [2:0]  cmd;
    logic [3:0]  pos;
    logic [31:0] val;
    int          roll;
    int          grow;
    int          top;
    repeat (n) begin
      grow = (model_count < 4) ? 60 : ((model_count > 12) ? 25 : 40);
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        cmd = CMD_UNUSED;
      end else if (roll < 2 + grow / 2) begin
        cmd = oat_pkg::CMD_APPEND;
      end else if (roll < 2 + grow) begin
        cmd = oat_pkg::CMD_INSERT;
      end else begin
        case ($urandom_range(0, 5))
          0, 1:    cmd = oat_pkg::CMD_DELETE;
          2:       cmd = oat_pkg::CMD_SEARCH;
          3:       cmd = oat_pkg::CMD_POP;
          4:       cmd = oat_pkg::CMD_MAX;
          default: cmd = oat_pkg::CMD_MIN;
        endcase
      end
      // mostly legal indexes, now and then any index
      top = (cmd == oat_pkg::CMD_INSERT) ? model_count : model_count - 1;
      if (top > 15) top = 15;
      if (top >= 0 && $urandom_range(0, 3) != 0) pos = 4'($urandom_range(0, top));
      else pos = 4'($urandom_range(0, 15));
      // small values and stored words make searches hit and ties appear
      case ($urandom_range(0, 3))
        0: val = $urandom_range(0, 8) - 4;
        1: val = (model_count > 0) ? model_words[$urandom_range(0, model_count - 1)]
                                   : $urandom;
        2: begin
          case ($urandom_range(0, 3))
            0:       val = 32'h7FFF_FFFF;
            1:       val = 32'h8000_0000;
            2:       val = '0;
            default: val = '1;
          endcase
        end
        default: val = $urandom;
      endcase
      send_word(cmd, pos, val);
    end
  endtask

  // Edges on an empty and a short table, every command, empty and bad index refusals
  task automatic test_reset_and_edges();
    send_word(oat_pkg::CMD_POP,    4'd0,  '0);
    send_word(oat_pkg::CMD_MAX,    4'd0,  '0);
    send_word(oat_pkg::CMD_MIN,    4'd0,  '0);
    send_word(oat_pkg::CMD_SEARCH, 4'd0,  '0);
    send_word(oat_pkg::CMD_DELETE, 4'd0,  '0);
    send_word(oat_pkg::CMD_INSERT, 4'd1,  32'd9);
    send_word(CMD_UNUSED,          4'd0,  '0);
    send_word(oat_pkg::CMD_INSERT, 4'd0,  32'h8000_0000);
    send_word(oat_pkg::CMD_APPEND, 4'd0,  32'h7FFF_FFFF);
    send_word(oat_pkg::CMD_INSERT, 4'd2,  32'hFFFF_FFFF);
    send_word(oat_pkg::CMD_INSERT, 4'd1,  '0);
    send_word(oat_pkg::CMD_INSERT, 4'd15, 32'd5);
    send_word(oat_pkg::CMD_MAX,    4'd0,  '0);
    send_word(oat_pkg::CMD_MIN,    4'd0,  '0);
    send_word(oat_pkg::CMD_SEARCH, 4'd0,  32'hFFFF_FFFF);
    send_word(oat_pkg::CMD_SEARCH, 4'd0,  32'd12345);
    send_word(oat_pkg::CMD_APPEND, 4'd0,  '0);
    send_word(oat_pkg::CMD_SEARCH, 4'd0,  '0);
    send_word(oat_pkg::CMD_DELETE, 4'd5,  '0);
    send_word(oat_pkg::CMD_DELETE, 4'd4,  '0);
    send_word(oat_pkg::CMD_DELETE, 4'd0,  '0);
    send_word(oat_pkg::CMD_DELETE, 4'd15, '0);
    send_word(CMD_UNUSED,          4'd15, 32'hFFFF_FFFF);
    send_word(oat_pkg::CMD_POP,    4'd0,  '0);
  endtask

  // Fill to capacity, poke the full table, then drain it completely
  task automatic test_fill_to_capacity();
    while (model_count < TABLE_DEPTH)
      send_word(oat_pkg::CMD_APPEND, 4'($urandom_range(0, 15)), $urandom);
    send_word(oat_pkg::CMD_APPEND, 4'd0,  32'd1);
    send_word(oat_pkg::CMD_INSERT, 4'd0,  32'd1);
    send_word(oat_pkg::CMD_MAX,    4'd0,  '0);
    send_word(oat_pkg::CMD_MIN,    4'd0,  '0);
    send_word(oat_pkg::CMD_SEARCH, 4'd0,  model_words[TABLE_DEPTH - 1]);
    send_word(oat_pkg::CMD_DELETE, 4'd15, '0);
    send_word(oat_pkg::CMD_INSERT, 4'd15, 32'h8000_0000);
    send_word(oat_pkg::CMD_DELETE, 4'd0,  '0);
    send_word(oat_pkg::CMD_INSERT, 4'd0,  32'h7FFF_FFFF);
    while (model_count > 0) send_word(oat_pkg::CMD_POP, 4'd0, '0);
    send_word(oat_pkg::CMD_POP, 4'd0, '0);
  endtask

  task automatic test_random_commands();
    run_mix(1200);
  endtask

  // Stall the receiver long enough that the block backs up into its input
  task automatic test_output_backpressure();
    long_hold_req = 1'b1;
    while (long_hold_req) @(posedge clk_i);
    run_mix(16);
  endtask

  // Closing stretch with no idling on either side
  task automatic test_back_to_back();
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    run_mix(380);
  endtask

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_ready_i   <= 1'b0;
        long_hold_req = 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin : check_results
    table_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(status_o), '0);
      end else begin
        want = pending_results.pop_front();
        if (int'(want.status) < $size(status_tally)) status_tally[want.status]++;
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (result_value_o !== want.value)
          report_mismatch("result_value", result_value_o, want.value);
        if (result_index_o !== want.index)
          report_mismatch("result_index", 32'(result_index_o), 32'(want.index));
        if (entry_count_o !== want.count)
          report_mismatch("entry_count", 32'(entry_count_o), 32'(want.count));
        if (empty_flag_o !== want.empty)
          report_mismatch("empty_flag", 32'(empty_flag_o), 32'(want.empty));
        if (full_flag_o !== want.full)
          report_mismatch("full_flag", 32'(full_flag_o), 32'(want.full));
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no handshake for %0d cycles, %0d results pending",
                 $time, WATCHDOG_LIMIT, pending_results.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_and_edges();
    test_fill_to_capacity();
    test_random_commands();
    test_output_backpressure();
    test_back_to_back();

    // Drop valid, wait out the last results, then watch for strays
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d commands, checked %0d results, one long output stall included",
             words_sent, results_seen);
    $display("Status mix: ok %0d, full %0d, empty %0d, bad index %0d, not found %0d",
             status_tally[oat_pkg::ST_OK], status_tally[oat_pkg::ST_FULL],
             status_tally[oat_pkg::ST_EMPTY], status_tally[oat_pkg::ST_BADIDX],
             status_tally[oat_pkg::ST_NOTFOUND]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/oat_pkg.sv
hw/rtl/ordered_array_table.sv
tb/sv/tb_ordered_array_table.sv
